// File: hdl/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared constants and types of the delimited token reverser.
// ----------------------------------------------------------------------------
package dtr_pkg;

  localparam int TOKEN_DEPTH    = 64;
  localparam int MAX_DELIMITERS = 8;

  localparam int ADDR_W   = $clog2(TOKEN_DEPTH);
  localparam int CNT_W    = $clog2(TOKEN_DEPTH + 1);
  localparam int RAM_AW   = ADDR_W + 1;
  localparam int RAM_SIZE = 2 ** RAM_AW;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam int DCNT_W  = 4;
  localparam int DELIM_W = 64;
  localparam int PEND_W  = 2;

  localparam logic [BYTE_W-1:0] NUL_BYTE = '0;
  localparam logic [POS_W-1:0]  POS_MAX  = '1;

  localparam logic REG_DELIM_BYTES = 1'b0;
  localparam logic REG_DELIM_COUNT = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] start;
    logic             forced;
    logic             bank;
  } dtr_cmd_t;

endpackage

// File: hdl/dtr_ram.sv
// ----------------------------------------------------------------------------
// dtr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dtr_queue.sv
// ----------------------------------------------------------------------------
// dtr_queue
// Two-entry queue of token flush commands between the front and back ends.
// ----------------------------------------------------------------------------
module dtr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dtr_pkg::dtr_cmd_t cmd_i,
  input  logic              pop_i,
  output logic              empty_o,
  output dtr_pkg::dtr_cmd_t head_o
);
  import dtr_pkg::*;

  dtr_cmd_t entry_q [2];
  logic     wr_ptr_q, wr_ptr_d;
  logic     rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push_i || pop_i)
    else $error("Command queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Command queue read while empty.");

endmodule

// File: hdl/dtr_front.sv
// ----------------------------------------------------------------------------
// dtr_front
// Accepts string bytes, classifies them, stores token bytes and issues flushes.
// ----------------------------------------------------------------------------
module dtr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dtr_pkg::BYTE_W-1:0]  s_axis_tdata,
  input  logic                        s_axis_tlast,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_index_i,
  input  logic [dtr_pkg::DELIM_W-1:0] cfg_data_i,
  input  logic                        done_i,
  output logic                        push_o,
  output dtr_pkg::dtr_cmd_t           cmd_o,
  output logic                        we_o,
  output logic [dtr_pkg::RAM_AW-1:0]  waddr_o
);
  import dtr_pkg::*;

  logic [DELIM_W-1:0] delims_q;
  logic [DCNT_W-1:0]  dcount_q;
  logic [CNT_W-1:0]   held_q, held_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic               bank_q, bank_d;
  logic [PEND_W-1:0]  pending_q, pending_d;
  logic [DCNT_W-1:0]  dcount_eff;
  logic               accept, is_nul, is_eos, is_delim;
  dtr_cmd_t           cmd_d;
  logic               push_d;

  assign s_axis_tready = (pending_q != PEND_W'(2));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_nul        = (s_axis_tdata == NUL_BYTE);
  assign is_eos        = s_axis_tlast || is_nul;

  always_comb begin
    dcount_eff = (dcount_q > DCNT_W'(MAX_DELIMITERS)) ? DCNT_W'(MAX_DELIMITERS) : dcount_q;
    is_delim   = 1'b0;
    for (int i = 0; i < MAX_DELIMITERS; i++) begin
      if ((DCNT_W'(i) < dcount_eff) && (delims_q[i*BYTE_W +: BYTE_W] == s_axis_tdata)) begin
        is_delim = 1'b1;
      end
    end
  end

  always_comb begin
    held_d       = held_q;
    pos_d        = pos_q;
    start_d      = start_q;
    bank_d       = bank_q;
    push_d       = 1'b0;
    we_o         = 1'b0;
    cmd_d.count  = held_q;
    cmd_d.start  = start_q;
    cmd_d.forced = 1'b0;
    cmd_d.bank   = bank_q;
    if (accept) begin
      if (!is_nul) begin
        if (is_delim) begin
          push_d = (held_q != '0);
          held_d = '0;
        end else begin
          we_o = 1'b1;
          if (held_q == '0) begin
            start_d = pos_q;
          end
          if (held_q == CNT_W'(TOKEN_DEPTH - 1)) begin
            push_d       = 1'b1;
            cmd_d.count  = CNT_W'(TOKEN_DEPTH);
            cmd_d.start  = start_d;
            cmd_d.forced = 1'b1;
            held_d       = '0;
          end else begin
            held_d = held_q + CNT_W'(1);
          end
        end
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      if (is_eos) begin
        if (held_d != '0) begin
          push_d      = 1'b1;
          cmd_d.count = held_d;
          cmd_d.start = start_d;
        end
        held_d  = '0;
        pos_d   = '0;
        start_d = '0;
      end
      if (push_d) begin
        bank_d = ~bank_q;
      end
    end
    pending_d = pending_q + {{(PEND_W-1){1'b0}}, push_d} - {{(PEND_W-1){1'b0}}, done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delims_q  <= '0;
      dcount_q  <= DCNT_W'(1);
      held_q    <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      bank_q    <= 1'b0;
      pending_q <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == REG_DELIM_BYTES)) begin
        delims_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == REG_DELIM_COUNT)) begin
        dcount_q <= cfg_data_i[DCNT_W-1:0];
      end
      held_q    <= held_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      bank_q    <= bank_d;
      pending_q <= pending_d;
    end
  end

  assign push_o  = push_d;
  assign cmd_o   = cmd_d;
  assign waddr_o = {bank_q, held_q[ADDR_W-1:0]};

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != PEND_W'(3))
    else $error("More token flushes outstanding than buffer banks.");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.count != '0) && (cmd_o.count <= CNT_W'(TOKEN_DEPTH)))
    else $error("Flush issued with an invalid byte count.");

endmodule

// File: hdl/dtr_back.sv
// ----------------------------------------------------------------------------
// dtr_back
// Reads a stored token last byte first and sends it on the output stream.
// ----------------------------------------------------------------------------
module dtr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  dtr_pkg::dtr_cmd_t          cmd_i,
  output logic                       pop_o,
  output logic                       re_o,
  output logic [dtr_pkg::RAM_AW-1:0] raddr_o,
  input  logic [dtr_pkg::BYTE_W-1:0] rdata_i,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser,
  output logic                       done_o
);
  import dtr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SEND} state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] idx_q;
  logic              bank_q;
  logic [POS_W-1:0]  start_q;
  logic              forced_q;

  assign pop_o         = (state_q == ST_IDLE) && !empty_i;
  assign re_o          = (state_q == ST_READ);
  assign raddr_o       = {bank_q, idx_q};
  assign m_axis_tvalid = (state_q == ST_SEND);
  assign m_axis_tdata  = {start_q, rdata_i};
  assign m_axis_tlast  = (idx_q == '0);
  assign m_axis_tuser  = forced_q;
  assign done_o        = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      bank_q   <= 1'b0;
      start_q  <= '0;
      forced_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            idx_q    <= ADDR_W'(cmd_i.count - CNT_W'(1));
            bank_q   <= cmd_i.bank;
            start_q  <= cmd_i.start;
            forced_q <= cmd_i.forced;
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (m_axis_tready) begin
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - ADDR_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_read_before_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(re_o))
    else $error("Output presented without a preceding buffer read.");

  a_done_only_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("Token finished without returning to idle.");

endmodule

// File: hdl/delimited_token_reverser_unit.sv
// ----------------------------------------------------------------------------
// delimited_token_reverser_unit
// Splits a byte string into delimited tokens and emits each token reversed.
// ----------------------------------------------------------------------------
// The input stream carries one string byte per item, with tlast on the final
// byte; a zero byte also ends the string. Bytes matching one of the configured
// delimiters separate tokens. Each token is stored in one of two buffer banks
// and then sent on the output stream last byte first, with the token's start
// offset, tlast on its final byte and tuser set when the token was cut because
// a bank filled. The configuration channel is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// An input item is taken while a bank is free, so a new token is gathered
// while the previous one drains. The output side reads each byte through the
// registered buffer read before sending it; a token's first byte appears once
// its flush is queued, popped by the idle back end and read from the buffer.
// After reset no token is held, the delimiter set is one zero byte and the
// count of delimiters in use is one. When the receiver stalls, the output
// holds and the input side keeps accepting until both banks hold tokens.
// ----------------------------------------------------------------------------
module delimited_token_reverser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // in_byte
  input  logic                        s_axis_tlast,  // end_of_string
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // token_byte, token_start
  output logic                        m_axis_tlast,  // token_last
  output logic                        m_axis_tuser,  // forced_split
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [dtr_pkg::DELIM_W-1:0] cfg_data_i
);
  import dtr_pkg::*;

  dtr_cmd_t          push_cmd, head_cmd;
  logic              push, pop, empty, done;
  logic              we, re;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [BYTE_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  dtr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_i        (done),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .we_o          (we),
    .waddr_o       (waddr)
  );

  dtr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  dtr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .done_o        (done)
  );

endmodule
